FILE: sv/qau_pkg.sv
// Shared types and constants of the quaternion arithmetic unit.
// Request and result item structs, operation codes, Q2.14 constants.
// No dependencies.
package qau_pkg;

    localparam int unsigned Q_FRAC  = 14;
    localparam int unsigned Q_WIDTH = 16;
    localparam int unsigned ACC_WIDTH = 35;

    localparam logic [1:0] OP_PRODUCT   = 2'd0;
    localparam logic [1:0] OP_CONJUGATE = 2'd1;
    localparam logic [1:0] OP_DOT       = 2'd2;
    localparam logic [1:0] OP_MATRIX    = 2'd3;

    localparam logic [1:0] LAST_COL = 2'd3;

    localparam logic signed [Q_WIDTH-1:0] Q_ONE = 16'sd16384;
    localparam logic signed [Q_WIDTH-1:0] Q_ZERO = 16'sd0;

    typedef struct packed {
        logic [1:0]                req_type;
        logic signed [Q_WIDTH-1:0] ax;
        logic signed [Q_WIDTH-1:0] ay;
        logic signed [Q_WIDTH-1:0] az;
        logic signed [Q_WIDTH-1:0] aw;
        logic signed [Q_WIDTH-1:0] bx;
        logic signed [Q_WIDTH-1:0] by;
        logic signed [Q_WIDTH-1:0] bz;
        logic signed [Q_WIDTH-1:0] bw;
    } req_t;

    typedef struct packed {
        logic signed [Q_WIDTH-1:0] value_0;
        logic signed [Q_WIDTH-1:0] value_1;
        logic signed [Q_WIDTH-1:0] value_2;
        logic signed [Q_WIDTH-1:0] value_3;
        logic                      last;
    } rsp_t;

endpackage

FILE: sv/qau_core.sv
// Combinational datapath of the quaternion arithmetic unit.
// Computes one result item of a request: product, conjugate, dot or one matrix column.
// Depends on qau_pkg.
module qau_core (
    input  qau_pkg::req_t     req,
    input  logic [1:0]        col,
    output qau_pkg::rsp_t     rsp
);

    localparam int unsigned AW = qau_pkg::ACC_WIDTH;
    localparam logic signed [AW-1:0] ONE_WIDE = AW'(signed'(64'sd1 <<< (2 * qau_pkg::Q_FRAC)));

    function automatic logic signed [qau_pkg::Q_WIDTH-1:0] scale_sat(
        input logic signed [AW-1:0] v
    );
        logic signed [AW-qau_pkg::Q_FRAC-1:0] q;
        q = $signed(v[AW-1:qau_pkg::Q_FRAC]);
        if (q > (AW - qau_pkg::Q_FRAC)'(32767)) begin
            return 16'sh7FFF;
        end else if (q < -(AW - qau_pkg::Q_FRAC)'(32768)) begin
            return 16'sh8000;
        end else begin
            return q[qau_pkg::Q_WIDTH-1:0];
        end
    endfunction

    function automatic logic signed [qau_pkg::Q_WIDTH-1:0] neg_sat(
        input logic signed [qau_pkg::Q_WIDTH-1:0] v
    );
        if (v == 16'sh8000) begin
            return 16'sh7FFF;
        end else begin
            return -v;
        end
    endfunction

    logic signed [15:0] x, y, z, w, bx, by, bz, bw;
    assign x  = req.ax;
    assign y  = req.ay;
    assign z  = req.az;
    assign w  = req.aw;
    assign bx = req.bx;
    assign by = req.by;
    assign bz = req.bz;
    assign bw = req.bw;

    // Hamilton product and dot terms
    logic signed [31:0] wbx, xbw, ybz, zby, wby, ybw, zbx, xbz;
    logic signed [31:0] wbz, zbw, xby, ybx, wbw, xbx, yby, zbz;
    assign wbx = w * bx;
    assign xbw = x * bw;
    assign ybz = y * bz;
    assign zby = z * by;
    assign wby = w * by;
    assign ybw = y * bw;
    assign zbx = z * bx;
    assign xbz = x * bz;
    assign wbz = w * bz;
    assign zbw = z * bw;
    assign xby = x * by;
    assign ybx = y * bx;
    assign wbw = w * bw;
    assign xbx = x * bx;
    assign yby = y * by;
    assign zbz = z * bz;

    // rotation matrix terms
    logic signed [31:0] x2, y2, z2, xy, xz, yz, wx, wy, wz;
    assign x2 = x * x;
    assign y2 = y * y;
    assign z2 = z * z;
    assign xy = x * y;
    assign xz = x * z;
    assign yz = y * z;
    assign wx = w * x;
    assign wy = w * y;
    assign wz = w * z;

    logic signed [AW-1:0] qx_sum, qy_sum, qz_sum, qw_sum, dot_sum;
    assign qx_sum = AW'(wbx) + AW'(xbw) + AW'(ybz) - AW'(zby);
    assign qy_sum = AW'(wby) + AW'(ybw) + AW'(zbx) - AW'(xbz);
    assign qz_sum = AW'(wbz) + AW'(zbw) + AW'(xby) - AW'(ybx);
    assign qw_sum = AW'(wbw) - AW'(xbx) - AW'(yby) - AW'(zbz);
    assign dot_sum = AW'(xbx) + AW'(yby) + AW'(zbz) + AW'(wbw);

    logic signed [AW-1:0] m00, m10, m20, m01, m11, m21, m02, m12, m22;
    assign m00 = ONE_WIDE - ((AW'(y2) + AW'(z2)) <<< 1);
    assign m10 = (AW'(xy) + AW'(wz)) <<< 1;
    assign m20 = (AW'(xz) - AW'(wy)) <<< 1;
    assign m01 = (AW'(xy) - AW'(wz)) <<< 1;
    assign m11 = ONE_WIDE - ((AW'(x2) + AW'(z2)) <<< 1);
    assign m21 = (AW'(yz) + AW'(wx)) <<< 1;
    assign m02 = (AW'(xz) + AW'(wy)) <<< 1;
    assign m12 = (AW'(yz) - AW'(wx)) <<< 1;
    assign m22 = ONE_WIDE - ((AW'(x2) + AW'(y2)) <<< 1);

    always_comb begin
        rsp = '0;
        case (req.req_type)
            qau_pkg::OP_PRODUCT: begin
                rsp.value_0 = scale_sat(qx_sum);
                rsp.value_1 = scale_sat(qy_sum);
                rsp.value_2 = scale_sat(qz_sum);
                rsp.value_3 = scale_sat(qw_sum);
                rsp.last    = 1'b1;
            end
            qau_pkg::OP_CONJUGATE: begin
                rsp.value_0 = neg_sat(x);
                rsp.value_1 = neg_sat(y);
                rsp.value_2 = neg_sat(z);
                rsp.value_3 = w;
                rsp.last    = 1'b1;
            end
            qau_pkg::OP_DOT: begin
                rsp.value_0 = scale_sat(dot_sum);
                rsp.value_1 = qau_pkg::Q_ZERO;
                rsp.value_2 = qau_pkg::Q_ZERO;
                rsp.value_3 = qau_pkg::Q_ZERO;
                rsp.last    = 1'b1;
            end
            default: begin
                rsp.last = (col == qau_pkg::LAST_COL);
                case (col)
                    2'd0: begin
                        rsp.value_0 = scale_sat(m00);
                        rsp.value_1 = scale_sat(m10);
                        rsp.value_2 = scale_sat(m20);
                        rsp.value_3 = qau_pkg::Q_ZERO;
                    end
                    2'd1: begin
                        rsp.value_0 = scale_sat(m01);
                        rsp.value_1 = scale_sat(m11);
                        rsp.value_2 = scale_sat(m21);
                        rsp.value_3 = qau_pkg::Q_ZERO;
                    end
                    2'd2: begin
                        rsp.value_0 = scale_sat(m02);
                        rsp.value_1 = scale_sat(m12);
                        rsp.value_2 = scale_sat(m22);
                        rsp.value_3 = qau_pkg::Q_ZERO;
                    end
                    default: begin
                        rsp.value_0 = qau_pkg::Q_ZERO;
                        rsp.value_1 = qau_pkg::Q_ZERO;
                        rsp.value_2 = qau_pkg::Q_ZERO;
                        rsp.value_3 = qau_pkg::Q_ONE;
                    end
                endcase
            end
        endcase
    end

endmodule

FILE: sv/quaternion_arithmetic_unit.sv
// Top level of the quaternion arithmetic unit: input register, datapath, result register.
// Depends on qau_pkg and qau_core.
//
// Q2.14 quaternion ALU. Product, conjugate and dot requests each give one result item and
// can be accepted every cycle while m_ready holds; a rotation matrix request gives four
// result items (columns 0..3, last set on column 3), one column per cycle through the
// shared datapath while m_ready holds; it keeps the input register until column 3 issues.
// The result register frees the input side while a finished item waits on m_ready.
module quaternion_arithmetic_unit (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  qau_pkg::req_t  s_item,
    output logic           m_valid,
    input  logic           m_ready,
    output qau_pkg::rsp_t  m_item
);

    logic           in_valid_reg, in_valid_next;
    qau_pkg::req_t  in_reg, in_next;
    logic [1:0]     col_reg, col_next;
    logic           out_valid_reg, out_valid_next;
    qau_pkg::rsp_t  out_reg, out_next;

    qau_pkg::rsp_t  core_rsp;
    logic           out_free;
    logic           issue;
    logic           item_done;

    qau_core u_core (
        .req (in_reg),
        .col (col_reg),
        .rsp (core_rsp)
    );

    assign out_free  = !out_valid_reg || m_ready;
    assign issue     = in_valid_reg && out_free;
    assign item_done = (in_reg.req_type != qau_pkg::OP_MATRIX) || (col_reg == qau_pkg::LAST_COL);
    assign s_ready   = !in_valid_reg || (issue && item_done);

    always_comb begin
        in_valid_next  = in_valid_reg;
        in_next        = in_reg;
        col_next       = col_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (issue) begin
            col_next = item_done ? 2'd0 : col_reg + 2'd1;
            if (item_done) begin
                in_valid_next = 1'b0;
            end
        end
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
            in_next       = s_item;
            col_next      = 2'd0;
        end

        if (issue) begin
            out_valid_next = 1'b1;
            out_next       = core_rsp;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            col_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            col_reg       <= col_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_reg  <= in_next;
        out_reg <= out_next;
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_reg;

endmodule
